@@ src/ttb_pkg.sv @@
// Shared types and constants for the translation table builder.
// No dependencies.
package ttb_pkg;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_MAP   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_TBL  = 2'd2;

  // Descriptor sizes that a map step can place.
  localparam logic [1:0] LVL_1G = 2'd1;
  localparam logic [1:0] LVL_2M = 2'd2;
  localparam logic [1:0] LVL_4K = 2'd3;

  localparam int unsigned SubWords = 512;
  localparam logic [35:0] Pages1G = 36'd262144;
  localparam logic [35:0] Pages2M = 36'd512;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_CLEAR, S_MAP_STEP, S_RD_SLOT,
    S_CHK_SLOT, S_FILL, S_PLACE, S_RD_WORD, S_RD_WAIT, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  va_bits;
    logic [35:0] phys_page;
    logic [63:0] virt_addr;
    logic [35:0] region_pages;
    logic [63:0] perm_bits;
    logic [63:0] attr_bits;
    logic [15:0] word_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
    logic [47:0] table_addr;
    logic [16:0] free_words;
  } rsp_t;

endpackage

@@ src/ttb_req_if.sv @@
// Valid/ready channel carrying one request transaction.
// Depends on ttb_pkg.
interface ttb_req_if;
  logic          valid;
  logic          ready;
  ttb_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/ttb_rsp_if.sv @@
// Valid/ready channel carrying one response transaction.
// Depends on ttb_pkg.
interface ttb_rsp_if;
  logic          valid;
  logic          ready;
  ttb_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/ttb_store.sv @@
// Single-port-write, single-read word store with a registered read port.
// No dependencies.
module ttb_store #(
  parameter int unsigned Words = 65536,
  parameter int unsigned Aw    = $clog2(Words)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [63:0]   rdata_o
);
  logic [63:0] mem [Words];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ src/translation_table_builder_top.sv @@
// Top level of the translation table builder: control sequencer and store.
// Depends on ttb_pkg, ttb_req_if, ttb_rsp_if and ttb_store.
//
//  channel   dir  content
//  req       in   operation, va_bits, phys_page, virt_addr, region_pages,
//                 perm_bits, attr_bits, word_index
//  rsp       out  status, read_data, table_addr, free_words
//  cfg       in   table_base_page (write enable and data)
//
// One transaction at a time; the request is accepted only in the idle state.
// A start writes the top-table entry and then clears the new level-1 words one
// by one. A map step places a 1GB block in the level-1 table directly, walks one
// table down for a 2MB block and two for a 4KB page, and fills every new
// sub-table word by word, all through the single store write port. The response
// then waits until it is accepted. The store is undefined after reset.
module translation_table_builder_top #(
  parameter int unsigned STORE_WORDS = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [35:0]  cfg_wdata_i,
  ttb_req_if.sink      req,
  ttb_rsp_if.source    rsp
);
  localparam int unsigned Aw = $clog2(STORE_WORDS);
  localparam int unsigned Cw = Aw + 1;
  localparam int unsigned L1W = 19;
  localparam logic [Cw-1:0] Words = Cw'(STORE_WORDS);
  localparam logic [Cw-1:0] Sub   = Cw'(ttb_pkg::SubWords);

  ttb_pkg::state_e state_q, state_d;
  logic [35:0]     base_q;
  logic [Cw-1:0]   free_q, free_d, l1_q, l1_d;
  logic [5:0]      width_q, width_d;
  logic            open_q, open_d;
  logic [5:0]      vb_q, vb_d;
  logic [15:0]     widx_q, widx_d;
  logic [63:0]     extra_q, extra_d;
  logic [35:0]     pg_q, pg_d, rem_q, rem_d;
  logic [47:0]     va_q, va_d;
  logic [1:0]      lvl_q, lvl_d, cur_q, cur_d;
  logic [Cw-1:0]   slot_q, slot_d, tbl_q, tbl_d;
  logic [Cw-1:0]   cnt_q, cnt_d, lim_q, lim_d;
  logic [63:0]     fill_q, fill_d, step_q, step_d;
  logic            clr_q, clr_d;
  ttb_pkg::rsp_t   out_q, out_d;

  logic            we;
  logic [Aw-1:0]   waddr, raddr;
  logic [63:0]     wdata, rdata;

  logic [5:0]      w_clamp;
  logic [L1W-1:0]  l1cnt_new, l1cnt;
  logic [17:0]     l1_off;
  logic [47:0]     vmask, ptr_off;
  logic            ptr_ok, child_ok, start_fits, sub_full, last_hop, is_ptr;
  logic            rd_in_range;
  logic [8:0]      sub_idx;
  logic [Cw-1:0]   map_slot, ptr_idx, child_ptr, child_new;
  logic [1:0]      lvl_pick;

  ttb_store #(.Words(STORE_WORDS), .Aw(Aw)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [47:0] waddr_of(logic [35:0] b, logic [Cw-1:0] i);
    return {b, 12'd0} + 48'({i, 3'd0});
  endfunction

  always_comb begin
    if (vb_q < 6'd40) w_clamp = 6'd40;
    else if (vb_q > 6'd48) w_clamp = 6'd48;
    else w_clamp = vb_q;
    l1cnt_new = L1W'(1) << (w_clamp - 6'd30);
    l1cnt = L1W'(1) << (width_q - 6'd30);
    start_fits = (32'(free_q) + 32'(Sub) + 32'(l1cnt_new)) <= STORE_WORDS;
    vmask = (48'd1 << width_q) - 48'd1;
    l1_off = va_q[47:30] & 18'(l1cnt - L1W'(1));
    map_slot = l1_q + Cw'(l1_off);
    // A stored pointer is judged against the current base, wrapped to 48 bits.
    ptr_off = (rdata[47:0] & 48'hffff_ffff_f000) - {base_q, 12'd0};
    ptr_ok = ptr_off < 48'({Words, 3'd0});
    ptr_idx = Cw'(ptr_off[47:3]);
    sub_idx = (cur_q == 2'd0) ? va_q[29:21] : va_q[20:12];
    child_ptr = ptr_idx + Cw'(sub_idx);
    child_new = tbl_q + Cw'(sub_idx);
    child_ok = 32'(child_ptr) < STORE_WORDS;
    sub_full = free_q > Words - Sub;
    last_hop = (cur_q + 2'd2 == lvl_q);
    is_ptr = rdata[1:0] == 2'b11;
    rd_in_range = 32'(widx_q) < STORE_WORDS;
    if (rem_q >= ttb_pkg::Pages1G && pg_q[17:0] == '0 && va_q[29:0] == '0)
      lvl_pick = ttb_pkg::LVL_1G;
    else if (rem_q >= ttb_pkg::Pages2M && pg_q[8:0] == '0 && va_q[20:0] == '0)
      lvl_pick = ttb_pkg::LVL_2M;
    else lvl_pick = ttb_pkg::LVL_4K;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ttb_pkg::S_IDLE: if (req.valid) begin
        case (req.data.operation)
          ttb_pkg::OP_START: state_d = ttb_pkg::S_START;
          ttb_pkg::OP_MAP:   state_d = ttb_pkg::S_MAP_STEP;
          ttb_pkg::OP_READ:  state_d = ttb_pkg::S_RD_WORD;
          default:           state_d = ttb_pkg::S_DONE;
        endcase
      end
      ttb_pkg::S_START: state_d = start_fits ? ttb_pkg::S_CLEAR : ttb_pkg::S_DONE;
      ttb_pkg::S_CLEAR: if (cnt_q == lim_q) state_d = ttb_pkg::S_DONE;
      ttb_pkg::S_MAP_STEP: begin
        if (!open_q || rem_q == 36'd0) state_d = ttb_pkg::S_DONE;
        else if (lvl_pick == ttb_pkg::LVL_1G) state_d = ttb_pkg::S_PLACE;
        else state_d = ttb_pkg::S_RD_SLOT;
      end
      ttb_pkg::S_RD_SLOT: state_d = ttb_pkg::S_CHK_SLOT;
      ttb_pkg::S_CHK_SLOT: begin
        if (is_ptr) begin
          if (!ptr_ok || !child_ok) state_d = ttb_pkg::S_DONE;
          else if (last_hop) state_d = ttb_pkg::S_PLACE;
          else state_d = ttb_pkg::S_RD_SLOT;
        end else if (sub_full) begin
          state_d = ttb_pkg::S_DONE;
        end else begin
          state_d = ttb_pkg::S_FILL;
        end
      end
      ttb_pkg::S_FILL: if (cnt_q == lim_q) begin
        state_d = last_hop ? ttb_pkg::S_PLACE : ttb_pkg::S_RD_SLOT;
      end
      ttb_pkg::S_PLACE: state_d = ttb_pkg::S_MAP_STEP;
      ttb_pkg::S_RD_WORD: state_d = ttb_pkg::S_RD_WAIT;
      ttb_pkg::S_RD_WAIT: state_d = ttb_pkg::S_DONE;
      ttb_pkg::S_DONE: if (rsp.ready) state_d = ttb_pkg::S_IDLE;
      default: state_d = ttb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    free_d = free_q; l1_d = l1_q; width_d = width_q; open_d = open_q;
    vb_d = vb_q; widx_d = widx_q; extra_d = extra_q;
    pg_d = pg_q; va_d = va_q; rem_d = rem_q; lvl_d = lvl_q; cur_d = cur_q;
    slot_d = slot_q; tbl_d = tbl_q; cnt_d = cnt_q; lim_d = lim_q;
    fill_d = fill_q; step_d = step_q; clr_d = clr_q;
    out_d = out_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = slot_q[Aw-1:0];
    case (state_q)
      ttb_pkg::S_IDLE: if (req.valid) begin
        out_d = '0;
        vb_d = req.data.va_bits;
        widx_d = req.data.word_index;
        extra_d = req.data.perm_bits | req.data.attr_bits;
        pg_d = req.data.phys_page;
        rem_d = req.data.region_pages;
        va_d = req.data.virt_addr[47:0] & vmask;
      end
      ttb_pkg::S_START: begin
        if (start_fits) begin
          we = 1'b1; waddr = free_q[Aw-1:0];
          wdata = {16'd0, waddr_of(base_q, free_q + Sub)} | 64'd3;
          out_d.table_addr = waddr_of(base_q, free_q);
          l1_d = free_q + Sub;
          cnt_d = free_q + Sub;
          lim_d = free_q + Sub + Cw'(l1cnt_new) - Cw'(1);
          free_d = free_q + Sub + Cw'(l1cnt_new);
          width_d = w_clamp; open_d = 1'b1;
        end else begin
          out_d.status = ttb_pkg::ST_FULL;
        end
      end
      ttb_pkg::S_CLEAR: begin
        we = 1'b1; waddr = cnt_q[Aw-1:0]; wdata = '0; cnt_d = cnt_q + Cw'(1);
      end
      ttb_pkg::S_MAP_STEP: begin
        if (!open_q) out_d.status = ttb_pkg::ST_NO_TBL;
        else if (rem_q != 36'd0) begin
          lvl_d = lvl_pick;
          slot_d = map_slot;
          cur_d = 2'd0;
        end
      end
      ttb_pkg::S_CHK_SLOT: begin
        // rdata holds the entry at slot_q, one level above the child table.
        if (is_ptr) begin
          if (!ptr_ok || !child_ok) out_d.status = ttb_pkg::ST_FULL;
          else begin
            slot_d = child_ptr;
            cur_d = cur_q + 2'd1;
          end
        end else if (sub_full) begin
          out_d.status = ttb_pkg::ST_FULL;
        end else begin
          we = 1'b1; waddr = slot_q[Aw-1:0];
          wdata = {16'd0, waddr_of(base_q, free_q)} | 64'd3;
          tbl_d = free_q; cnt_d = free_q; lim_d = free_q + Sub - Cw'(1);
          free_d = free_q + Sub;
          // A block is split; an invalid or reserved entry gives a cleared table.
          clr_d = rdata[1:0] != 2'b01; fill_d = rdata;
          step_d = (cur_q == 2'd0) ? 64'h20_0000 : 64'h1000;
        end
      end
      ttb_pkg::S_FILL: begin
        we = 1'b1; waddr = cnt_q[Aw-1:0]; wdata = clr_q ? 64'd0 : fill_q;
        fill_d = fill_q + step_q; cnt_d = cnt_q + Cw'(1);
        if (cnt_q == lim_q) begin
          slot_d = child_new;
          cur_d = cur_q + 2'd1;
        end
      end
      ttb_pkg::S_PLACE: begin
        we = 1'b1; waddr = slot_q[Aw-1:0];
        wdata = {16'd0, pg_q, 12'd0} | extra_q | 64'd1;
        if (lvl_q == ttb_pkg::LVL_4K) wdata = wdata | 64'd3;
        if (lvl_q == ttb_pkg::LVL_1G) begin
          pg_d = pg_q + ttb_pkg::Pages1G;
          va_d = (va_q + 48'h4000_0000) & vmask;
          rem_d = rem_q - ttb_pkg::Pages1G;
        end else if (lvl_q == ttb_pkg::LVL_2M) begin
          pg_d = pg_q + ttb_pkg::Pages2M;
          va_d = (va_q + 48'h20_0000) & vmask;
          rem_d = rem_q - ttb_pkg::Pages2M;
        end else begin
          pg_d = pg_q + 36'd1;
          va_d = (va_q + 48'h1000) & vmask;
          rem_d = rem_q - 36'd1;
        end
      end
      ttb_pkg::S_RD_WORD: raddr = Aw'(widx_q);
      ttb_pkg::S_RD_WAIT: out_d.read_data = rd_in_range ? rdata : 64'd0;
      default: ;
    endcase
    out_d.free_words = 17'(free_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttb_pkg::S_IDLE; base_q <= '0; free_q <= '0; l1_q <= '0;
      width_q <= 6'd40; open_q <= 1'b0;
    end else begin
      if (cfg_we_i) base_q <= cfg_wdata_i;
      state_q <= state_d;
      free_q <= free_d; l1_q <= l1_d; width_q <= width_d; open_q <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vb_q <= vb_d; widx_q <= widx_d; extra_q <= extra_d;
    pg_q <= pg_d; va_q <= va_d; rem_q <= rem_d; lvl_q <= lvl_d; cur_q <= cur_d;
    slot_q <= slot_d; tbl_q <= tbl_d; cnt_q <= cnt_d; lim_q <= lim_d;
    fill_q <= fill_d; step_q <= step_d; clr_q <= clr_d; out_q <= out_d;
  end

  assign req.ready = state_q == ttb_pkg::S_IDLE;
  assign rsp.valid = state_q == ttb_pkg::S_DONE;
  assign rsp.data = out_q;
endmodule
